FILE: rtl/core/cube_face_orientation_classifier_core_defines.svh
// Assertion macros shared by the cube face orientation classifier RTL
`ifndef CUBE_FACE_ORIENTATION_CLASSIFIER_CORE_DEFINES_SVH
`define CUBE_FACE_ORIENTATION_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, quiet during rst
`define CFOC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfoc check failed");

// Next-cycle implication, sampled on clk, quiet during rst
`define CFOC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfoc check failed");

`else

`define CFOC_ASSERT_NOW(label, ante, cons)
`define CFOC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/core/cfoc_pkg.sv
// Shared types and constant tables for the cube face orientation classifier
package cfoc_pkg;

  localparam int NUM_FACES   = 6;
  localparam int FACE_IDX_W  = 3;
  localparam int OUT_TDATA_W = 24;

  typedef logic [FACE_IDX_W-1:0] face_idx_t;

  // Highest legal face or position index
  localparam face_idx_t FACE_LAST = 3'd5;

  // Face/position order: +z, -x, -y, +x, +y, -z
  localparam logic [1:0] FACE_AXIS [NUM_FACES] = '{2'd2, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2};
  localparam logic       FACE_NEG  [NUM_FACES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

endpackage

FILE: rtl/core/cfoc_argmax.sv
// Six-way signed maximum search, lowest index wins on a tie
module cfoc_argmax #(
  parameter int VAL_W = 34
) (
  input  logic signed [VAL_W-1:0] cand [cfoc_pkg::NUM_FACES],
  output cfoc_pkg::face_idx_t     best
);

  logic signed [VAL_W-1:0] v01, v23, v45, v03;
  cfoc_pkg::face_idx_t     i01, i23, i45, i03;

  // Reduce in a short tree; the later operand only wins when strictly greater
  always_comb begin
    if (cand[1] > cand[0]) begin
      v01 = cand[1]; i01 = 3'd1;
    end else begin
      v01 = cand[0]; i01 = 3'd0;
    end
    if (cand[3] > cand[2]) begin
      v23 = cand[3]; i23 = 3'd3;
    end else begin
      v23 = cand[2]; i23 = 3'd2;
    end
    if (cand[5] > cand[4]) begin
      v45 = cand[5]; i45 = 3'd5;
    end else begin
      v45 = cand[4]; i45 = 3'd4;
    end
    if (v23 > v01) begin
      v03 = v23; i03 = i23;
    end else begin
      v03 = v01; i03 = i01;
    end
    if (v45 > v03) begin
      best = i45;
    end else begin
      best = i03;
    end
  end

endmodule

FILE: rtl/core/cube_face_orientation_classifier_core.sv
// Top level: quaternion in, face-to-position map out
//
// Channel | Direction | Contents
// s_*     | in        | quaternion w, x, y, z (QUAT_WIDTH bits each, signed)
// m_*     | out       | six 3-bit face indices, one per world position
//
// One transaction per cycle sustained while m_* does not stall.
// Stages: input register, product register, matrix entry register, result register.
// rst clears the stage valid flags and the face map (all positions read face 0).
// A stall on m_* holds every stage; s_tready drops only while the result is held.
module cube_face_orientation_classifier_core #(
  parameter int QUAT_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // quat_w, quat_x, quat_y, quat_z (lowest first), zero padded to bytes
  input  logic [8*((4*QUAT_WIDTH+7)/8)-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // face_at_top, face_at_neg_x, face_at_neg_y, face_at_pos_x, face_at_pos_y,
  // face_at_bottom (lowest first), zero padded to 24 bits
  output logic [cfoc_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  `include "cube_face_orientation_classifier_core_defines.svh"

  localparam int PW = 2*QUAT_WIDTH;
  localparam int EW = 2*QUAT_WIDTH + 2;
  localparam logic signed [EW-1:0] DIAG_BIAS = {{(EW-1){1'b0}}, 1'b1} << (2*QUAT_WIDTH-5);

  logic adv;
  logic v_in, v_prod, v_ent;

  logic signed [QUAT_WIDTH-1:0] qw, qx, qy, qz;
  logic signed [PW-1:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;
  logic signed [EW-1:0] ent_pos [3][3];
  logic signed [EW-1:0] ent_neg [3][3];
  logic signed [EW-1:0] cand [cfoc_pkg::NUM_FACES][cfoc_pkg::NUM_FACES];
  cfoc_pkg::face_idx_t  best [cfoc_pkg::NUM_FACES];
  cfoc_pkg::face_idx_t  face_at_position      [cfoc_pkg::NUM_FACES];
  cfoc_pkg::face_idx_t  face_at_position_next [cfoc_pkg::NUM_FACES];

  // Advance the whole pipe unless a finished result is still waiting
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v_in     <= 1'b0;
      v_prod   <= 1'b0;
      v_ent    <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v_in     <= s_tvalid;
      v_prod   <= v_in;
      v_ent    <= v_prod;
      m_tvalid <= v_ent;
    end
  end

  // Capture the quaternion
  always_ff @(posedge clk) begin
    if (adv) begin
      qw <= $signed(s_tdata[QUAT_WIDTH-1:0]);
      qx <= $signed(s_tdata[2*QUAT_WIDTH-1:QUAT_WIDTH]);
      qy <= $signed(s_tdata[3*QUAT_WIDTH-1:2*QUAT_WIDTH]);
      qz <= $signed(s_tdata[4*QUAT_WIDTH-1:3*QUAT_WIDTH]);
    end
  end

  // Form the ten exact products
  always_ff @(posedge clk) begin
    if (adv) begin
      p_ww <= qw * qw;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_zz <= qz * qz;
      p_xy <= qx * qy;
      p_wz <= qw * qz;
      p_xz <= qx * qz;
      p_wy <= qw * qy;
      p_yz <= qy * qz;
      p_wx <= qw * qx;
    end
  end

  // Build half matrix entries and their negations side by side
  always_ff @(posedge clk) begin
    if (adv) begin
      ent_pos[0][0] <= EW'(p_ww) + EW'(p_xx) - DIAG_BIAS;
      ent_pos[0][1] <= EW'(p_xy) + EW'(p_wz);
      ent_pos[0][2] <= EW'(p_xz) - EW'(p_wy);
      ent_pos[1][0] <= EW'(p_xy) - EW'(p_wz);
      ent_pos[1][1] <= EW'(p_ww) + EW'(p_yy) - DIAG_BIAS;
      ent_pos[1][2] <= EW'(p_yz) + EW'(p_wx);
      ent_pos[2][0] <= EW'(p_wy) + EW'(p_xz);
      ent_pos[2][1] <= EW'(p_yz) - EW'(p_wx);
      ent_pos[2][2] <= EW'(p_ww) + EW'(p_zz) - DIAG_BIAS;
      ent_neg[0][0] <= DIAG_BIAS - EW'(p_ww) - EW'(p_xx);
      ent_neg[0][1] <= -EW'(p_xy) - EW'(p_wz);
      ent_neg[0][2] <= EW'(p_wy) - EW'(p_xz);
      ent_neg[1][0] <= EW'(p_wz) - EW'(p_xy);
      ent_neg[1][1] <= DIAG_BIAS - EW'(p_ww) - EW'(p_yy);
      ent_neg[1][2] <= -EW'(p_yz) - EW'(p_wx);
      ent_neg[2][0] <= -EW'(p_wy) - EW'(p_xz);
      ent_neg[2][1] <= EW'(p_wx) - EW'(p_yz);
      ent_neg[2][2] <= DIAG_BIAS - EW'(p_ww) - EW'(p_zz);
    end
  end

  // Route signed entries: face row against each position column
  always_comb begin
    for (int i = 0; i < cfoc_pkg::NUM_FACES; i++) begin
      for (int k = 0; k < cfoc_pkg::NUM_FACES; k++) begin
        if (cfoc_pkg::FACE_NEG[i] ^ cfoc_pkg::FACE_NEG[k]) begin
          cand[i][k] = ent_neg[cfoc_pkg::FACE_AXIS[i]][cfoc_pkg::FACE_AXIS[k]];
        end else begin
          cand[i][k] = ent_pos[cfoc_pkg::FACE_AXIS[i]][cfoc_pkg::FACE_AXIS[k]];
        end
      end
    end
  end

  // Find the nearest world position for every face
  for (genvar g = 0; g < cfoc_pkg::NUM_FACES; g++) begin : g_face
    cfoc_argmax #(
      .VAL_W (EW)
    ) u_argmax (
      .cand (cand[g]),
      .best (best[g])
    );
  end

  // Claim positions in face order; later faces overwrite earlier ones
  always_comb begin
    face_at_position_next = face_at_position;
    for (int i = 0; i < cfoc_pkg::NUM_FACES; i++) begin
      face_at_position_next[best[i]] = cfoc_pkg::FACE_IDX_W'(i);
    end
  end

  // Hold the face map; it doubles as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < cfoc_pkg::NUM_FACES; k++) begin
        face_at_position[k] <= '0;
      end
    end else if (adv && v_ent) begin
      face_at_position <= face_at_position_next;
    end
  end

  // Pack the result
  always_comb begin
    m_tdata = '0;
    for (int k = 0; k < cfoc_pkg::NUM_FACES; k++) begin
      m_tdata[k*cfoc_pkg::FACE_IDX_W +: cfoc_pkg::FACE_IDX_W] = face_at_position[k];
    end
  end

  // Checks
  `CFOC_ASSERT_NOW(a_face_range, 1'b1,
    (face_at_position[0] <= cfoc_pkg::FACE_LAST) &&
    (face_at_position[1] <= cfoc_pkg::FACE_LAST) &&
    (face_at_position[2] <= cfoc_pkg::FACE_LAST) &&
    (face_at_position[3] <= cfoc_pkg::FACE_LAST) &&
    (face_at_position[4] <= cfoc_pkg::FACE_LAST) &&
    (face_at_position[5] <= cfoc_pkg::FACE_LAST))
  `CFOC_ASSERT_NEXT(a_map_idle, !(adv && v_ent), $stable(m_tdata))
  `CFOC_ASSERT_NEXT(a_in_to_prod, s_tvalid && s_tready, v_in)
  `CFOC_ASSERT_NOW(a_out_source, $rose(m_tvalid), $past(v_ent))

endmodule
